// ===== rtl/core/nkc_pkg.sv =====
// ----------------------------------------------------------------------------
// nkc_pkg
// Shared types, constants and helpers of the normalized kernel convolution.
// ----------------------------------------------------------------------------
package nkc_pkg;

   localparam int GRID           = 5;
   localparam int COEF_COUNT     = GRID * GRID;
   localparam int COEF_W         = 8;
   localparam int NORM_W         = 13;
   localparam int QLIMIT         = 65280;
   localparam int RESULT_W       = 17;
   localparam int ROW_W          = 16;
   localparam int OUT_COL_W      = 10;
   localparam int FRAME_W_BITS   = 11;
   localparam int KSIZE_W        = 3;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int RSP_DATA_W     = 48;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_KERNEL = 5;
   localparam int DEF_PIXEL_BITS = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_WORD_0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_WORD_1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_WORD_2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_WORD_3  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_H     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_W     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_ROWS,
      ST_TOTAL,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

   // Kernel size in use: zero counts as one, even drops to odd, cap at lim (odd).
   function automatic logic [KSIZE_W-1:0] eff_size(input logic [KSIZE_W-1:0] v,
                                                   input logic [KSIZE_W-1:0] lim);
      logic [KSIZE_W-1:0] s;
      s = v;
      if (s == '0) s = KSIZE_W'(1);
      if (!s[0]) s = s - KSIZE_W'(1);
      if (s > lim) s = lim;
      return s;
   endfunction

   // Magnitude of a signed coefficient byte, unsigned (-128 gives 128).
   function automatic logic [COEF_W-1:0] coef_mag(input logic [COEF_W-1:0] c);
      return c[COEF_W-1] ? COEF_W'(-c) : c;
   endfunction

endpackage

// ===== rtl/core/normalized_kernel_convolution.sv =====
// ----------------------------------------------------------------------------
// normalized_kernel_convolution
// Centered 2D convolution of a raster pixel stream, normalized by the sum of
// absolute coefficients, signed Q9.8 result.
// ----------------------------------------------------------------------------
// One pixel is in work at a time. The line store is a single memory of
// MAX_WIDTH rows, each row holding MAX_KERNEL-1 pixels of one column; a
// pixel reads its column, and the next cycle shifts the window and writes
// the column back with the new pixel. A pixel with no result returns to
// idle after the load, a border or zero-normalizer result goes straight to
// output, and an interior result passes multiply, row sums, total and the
// bit-serial divider, one quotient bit per cycle. A finished result waits in
// the output register while the next pixel is taken. The normalizer follows
// coefficient and kernel size writes through registered row sums and total.
// ----------------------------------------------------------------------------
module normalized_kernel_convolution
   import nkc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]      req_tdata,  // pixel
   input  logic                                 req_tuser,  // first_of_frame
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_DATA_W-1:0]                rsp_tdata,  // result_value, out_row, out_col
   output logic                                 rsp_tuser,  // norm_zero
   input  logic                                 csr_we,
   input  logic [CSR_INDEX_W-1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]                csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int FW_W    = COL_W + 1;
   localparam int NLINES  = MAX_KERNEL - 1;
   localparam int SLOT_W  = $clog2(NLINES);
   localparam int LINE_W  = NLINES * PIXEL_BITS;
   localparam int KTAPS   = (MAX_KERNEL < GRID) ? MAX_KERNEL : GRID;
   localparam int KLIM    = (KTAPS % 2 == 0) ? KTAPS - 1 : KTAPS;
   localparam int PROD_W  = PIXEL_BITS + COEF_W + 1;
   localparam int RSUM_W  = PROD_W + 3;
   localparam int ACC_W   = RSUM_W + 3;
   localparam int DIV_W   = ACC_W + 8;
   localparam int ABSR_W  = COEF_W + 3;

   // configuration
   logic [COEF_W-1:0]       coef_ff [COEF_COUNT];
   logic [KSIZE_W-1:0]      kh_raw_ff, kw_raw_ff;
   logic [FRAME_W_BITS-1:0] fw_raw_ff;
   logic [ROW_W-1:0]        fh_raw_ff;

   logic [KSIZE_W-1:0]      kh_eff, kw_eff;
   logic [KSIZE_W-2:0]      hh, hw;
   logic [FW_W-1:0]         fw_eff;
   logic [ROW_W:0]          fh_eff;

   logic [ABSR_W-1:0]       nrow_ff [KTAPS];
   logic [ABSR_W-1:0]       nrow_in [KTAPS];
   logic [NORM_W-1:0]       norm_ff;
   logic [NORM_W-1:0]       norm_in;

   // position and control
   state_type               state_ff, state_in;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_ff;
   logic [SLOT_W-1:0]       slot_ff;

   logic                    accept;
   logic [PIXEL_BITS-1:0]   pix;
   logic [ROW_W-1:0]        r_cur;
   logic [COL_W-1:0]        c_cur;
   logic [SLOT_W-1:0]       s_cur;
   logic [ROW_W-1:0]        orow;
   logic [COL_W-1:0]        ocol;
   logic                    emit, interior;
   logic [FW_W-1:0]         c_next;
   logic [ROW_W:0]          r_next;

   // item in work
   logic [PIXEL_BITS-1:0]   pix_ff;
   logic [COL_W-1:0]        addr_ff;
   logic [SLOT_W-1:0]       wslot_ff;
   logic                    emit_ff, work_ff;
   logic [ROW_W-1:0]        orow_ff;
   logic [COL_W-1:0]        ocol_ff;

   // line store
   logic [LINE_W-1:0]       line_mem [MAX_WIDTH];
   logic [LINE_W-1:0]       mem_q;
   logic [LINE_W-1:0]       line_wr;
   logic [PIXEL_BITS-1:0]   col_new [MAX_KERNEL];

   // window and arithmetic
   logic [PIXEL_BITS-1:0]   win_ff [MAX_KERNEL][MAX_KERNEL];
   logic signed [PROD_W-1:0] prod_ff [KTAPS][KTAPS];
   logic signed [RSUM_W-1:0] rsum_ff [KTAPS];
   logic signed [RSUM_W-1:0] rsum_in [KTAPS];
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic [ACC_W-1:0]        acc_mag;
   logic                    div_start, div_done;
   logic [DIV_W-1:0]        quotient;
   logic [RESULT_W-1:0]     qclamp;
   logic [RESULT_W-1:0]     result_ff;

   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_nz_ff;
   logic                    out_load;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < COEF_COUNT; k++) coef_ff[k] <= '0;
         kh_raw_ff <= KSIZE_W'(3);
         kw_raw_ff <= KSIZE_W'(3);
         fw_raw_ff <= FRAME_W_BITS'(640);
         fh_raw_ff <= ROW_W'(480);
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_WORD_0: for (int k = 0; k < 8; k++) coef_ff[k] <= csr_wdata[k*8 +: 8];
            CSR_COEF_WORD_1: for (int k = 0; k < 8; k++) coef_ff[8+k] <= csr_wdata[k*8 +: 8];
            CSR_COEF_WORD_2: for (int k = 0; k < 8; k++) coef_ff[16+k] <= csr_wdata[k*8 +: 8];
            CSR_COEF_WORD_3: coef_ff[24] <= csr_wdata[7:0];
            CSR_KERNEL_H:     kh_raw_ff <= csr_wdata[KSIZE_W-1:0];
            CSR_KERNEL_W:     kw_raw_ff <= csr_wdata[KSIZE_W-1:0];
            CSR_FRAME_WIDTH:  fw_raw_ff <= csr_wdata[FRAME_W_BITS-1:0];
            CSR_FRAME_HEIGHT: fh_raw_ff <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      kh_eff = eff_size(kh_raw_ff, KSIZE_W'(KLIM));
      kw_eff = eff_size(kw_raw_ff, KSIZE_W'(KLIM));
      hh     = kh_eff[KSIZE_W-1:1];
      hw     = kw_eff[KSIZE_W-1:1];
      if (fw_raw_ff == '0)
         fw_eff = FW_W'(1);
      else if (32'(fw_raw_ff) > MAX_WIDTH)
         fw_eff = FW_W'(MAX_WIDTH);
      else
         fw_eff = FW_W'(fw_raw_ff);
      fh_eff = (fh_raw_ff == '0) ? (ROW_W+1)'(1) : {1'b0, fh_raw_ff};
   end

   // normalizer: registered row sums of |coef|, then their total
   always_comb begin
      for (int i = 0; i < KTAPS; i++) begin
         nrow_in[i] = '0;
         for (int j = 0; j < KTAPS; j++) begin
            if (KSIZE_W'(i) < kh_eff && KSIZE_W'(j) < kw_eff)
               nrow_in[i] = nrow_in[i] + ABSR_W'(coef_mag(coef_ff[i*GRID+j]));
         end
      end
      norm_in = '0;
      for (int i = 0; i < KTAPS; i++) norm_in = norm_in + NORM_W'(nrow_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KTAPS; i++) nrow_ff[i] <= '0;
         norm_ff <= '0;
      end else begin
         for (int i = 0; i < KTAPS; i++) nrow_ff[i] <= nrow_in[i];
         norm_ff <= norm_in;
      end
   end

   // ---------------------------------------------------------- input side
   assign accept = req_tvalid && req_tready;
   assign pix    = req_tdata[PIXEL_BITS-1:0];

   always_comb begin
      r_cur    = req_tuser ? '0 : row_ff;
      c_cur    = req_tuser ? '0 : col_ff;
      s_cur    = req_tuser ? '0 : slot_ff;
      emit     = (r_cur >= ROW_W'(hh)) && (c_cur >= COL_W'(hw));
      orow     = r_cur - ROW_W'(hh);
      ocol     = c_cur - COL_W'(hw);
      interior = (orow >= ROW_W'(hh)) && (ocol >= COL_W'(hw)) &&
                 ({1'b0, r_cur} < fh_eff) && ({1'b0, c_cur} < fw_eff);
      c_next   = {1'b0, c_cur} + FW_W'(1);
      r_next   = {1'b0, r_cur} + (ROW_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         if (c_next >= fw_eff) begin
            col_ff <= '0;
            if (r_next >= fh_eff) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= r_next[ROW_W-1:0];
               slot_ff <= (s_cur == SLOT_W'(NLINES - 1)) ? '0 : s_cur + SLOT_W'(1);
            end
         end else begin
            col_ff <= c_next[COL_W-1:0];
            row_ff <= r_cur;
            slot_ff <= s_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= pix;
         addr_ff  <= c_cur;
         wslot_ff <= s_cur;
         emit_ff  <= emit;
         work_ff  <= emit && interior && (norm_ff != '0);
         orow_ff  <= orow;
         ocol_ff  <= ocol;
      end
   end

   // ---------------------------------------------------------- line store
   always_ff @(posedge clock) begin
      if (accept) mem_q <= line_mem[c_cur];
      if (state_ff == ST_LOAD) line_mem[addr_ff] <= line_wr;
   end

   always_comb begin
      logic [SLOT_W:0] t;
      t       = '0;
      line_wr = mem_q;
      line_wr[wslot_ff*PIXEL_BITS +: PIXEL_BITS] = pix_ff;
      col_new[MAX_KERNEL-1] = pix_ff;
      for (int i = 1; i < MAX_KERNEL; i++) begin
         t = {1'b0, wslot_ff} + (SLOT_W+1)'(NLINES - i);
         if (t >= (SLOT_W+1)'(NLINES)) t = t - (SLOT_W+1)'(NLINES);
         col_new[MAX_KERNEL-1-i] = mem_q[t[SLOT_W-1:0]*PIXEL_BITS +: PIXEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MAX_KERNEL; w++)
            for (int j = 0; j < MAX_KERNEL; j++) win_ff[w][j] <= '0;
      end else if (state_ff == ST_LOAD) begin
         // shift left, newest column enters on the right
         for (int w = 0; w < MAX_KERNEL; w++) begin
            for (int j = 0; j < MAX_KERNEL - 1; j++) win_ff[w][j] <= win_ff[w][j+1];
            win_ff[w][MAX_KERNEL-1] <= col_new[w];
         end
      end
   end

   // ---------------------------------------------------------- arithmetic
   always_comb begin
      for (int i = 0; i < KTAPS; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KTAPS; j++) rsum_in[i] = rsum_in[i] + RSUM_W'(prod_ff[i][j]);
      end
      acc_in = '0;
      for (int i = 0; i < KTAPS; i++) acc_in = acc_in + ACC_W'(rsum_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         for (int i = 0; i < KTAPS; i++)
            for (int j = 0; j < KTAPS; j++)
               prod_ff[i][j] <= (KSIZE_W'(i) < kh_eff && KSIZE_W'(j) < kw_eff) ?
                  PROD_W'($signed(coef_ff[i*GRID+j]) *
                          $signed({1'b0, win_ff[MAX_KERNEL-1-i][MAX_KERNEL-1-j]})) :
                  '0;
      end
      if (state_ff == ST_ROWS) begin
         for (int i = 0; i < KTAPS; i++) rsum_ff[i] <= rsum_in[i];
      end
      if (state_ff == ST_TOTAL) acc_ff <= acc_in;
   end

   assign acc_mag   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign div_start = (state_ff == ST_START);

   nkc_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (NORM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({acc_mag, 8'b0}),
      .divisor  (norm_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign qclamp = (quotient > DIV_W'(QLIMIT)) ? RESULT_W'(QLIMIT) : quotient[RESULT_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD && !work_ff) result_ff <= '0;
      else if (state_ff == ST_DIV && div_done)
         result_ff <= acc_ff[ACC_W-1] ? RESULT_W'(-qclamp) : qclamp;
   end

   // ---------------------------------------------------------- control
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (!emit_ff)      state_in = ST_IDLE;
            else if (!work_ff) state_in = ST_OUT;
            else               state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_ROWS;
         ST_ROWS:  state_in = ST_TOTAL;
         ST_TOTAL: state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------- output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= RSP_DATA_W'({OUT_COL_W'(ocol_ff), orow_ff, result_ff});
         rsp_nz_ff   <= (norm_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_nz_ff;

endmodule

// ===== rtl/core/nkc_div.sv =====
// ----------------------------------------------------------------------------
// nkc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nkc_div
   import nkc_pkg::*;
#(
   parameter int DIVIDEND_W = 31,
   parameter int DIVISOR_W  = NORM_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DIVIDEND_W - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
         rem_ff <= fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== tb/tb_normalized_kernel_convolution.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_normalized_kernel_convolution
// Streams raster pixels through the normalized convolution under a range of
// kernel and frame settings, predicts each result in a scoreboard and checks
// every result beat field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_normalized_kernel_convolution
   import nkc_pkg::*;
();

   localparam int LINES      = 4;
   localparam int MAXW       = 1024;
   localparam int WATCHDOG   = 5000;
   localparam int DRAIN      = 100;

   typedef struct packed {
      logic [RESULT_W-1:0]  value;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 norm_zero;
   } conv_result_type;

   class conv_scoreboard;
      logic [63:0]  regs [8];
      logic [7:0]   lines [LINES][MAXW];
      logic [7:0]   win [5][5];
      int unsigned  row_cnt, col_cnt, norm;
      conv_result_type pending [$];
      int           failures;

      function new();
         regs = '{default: '0};
         regs[CSR_KERNEL_H] = 3;
         regs[CSR_KERNEL_W] = 3;
         regs[CSR_FRAME_WIDTH] = 640;
         regs[CSR_FRAME_HEIGHT] = 480;
         foreach (lines[i, j]) lines[i][j] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         row_cnt = 0;
         col_cnt = 0;
         norm = 0;
         failures = 0;
      endfunction

      function int coef(int n);
         logic [7:0] b;
         b = regs[n >> 3][(n & 7) * 8 +: 8];
         return int'($signed(b));
      endfunction

      function int ksize(logic [63:0] v);
         int s;
         s = int'(v[2:0]);
         if (s == 0) s = 1;
         if (s % 2 == 0) s = s - 1;
         if (s > 5) s = 5;
         return s;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] v);
         int kh, kw, c;
         case (idx)
            CSR_COEF_WORD_3:  v = v & 64'hFF;
            CSR_KERNEL_H:     v = v & 64'h7;
            CSR_KERNEL_W:     v = v & 64'h7;
            CSR_FRAME_WIDTH:  v = v & 64'h7FF;
            CSR_FRAME_HEIGHT: v = v & 64'hFFFF;
            default: ;
         endcase
         regs[idx] = v;
         kh = ksize(regs[CSR_KERNEL_H]);
         kw = ksize(regs[CSR_KERNEL_W]);
         norm = 0;
         for (int i = 0; i < kh; i++) begin
            for (int j = 0; j < kw; j++) begin
               c = coef(i * GRID + j);
               norm += (c < 0) ? -c : c;
            end
         end
      endfunction

      function void note_pixel(logic [7:0] pix, logic first);
         int unsigned fw, fh, r, c, cs, base, slot;
         int kh, kw, hh, hw;
         longint acc, q;
         bit interior;
         conv_result_type res;
         fw = int'(regs[CSR_FRAME_WIDTH]);
         if (fw == 0) fw = 1;
         if (fw > MAXW) fw = MAXW;
         fh = int'(regs[CSR_FRAME_HEIGHT]);
         if (fh == 0) fh = 1;
         kh = ksize(regs[CSR_KERNEL_H]);
         kw = ksize(regs[CSR_KERNEL_W]);
         hh = kh / 2;
         hw = kw / 2;
         if (first) begin
            row_cnt = 0;
            col_cnt = 0;
         end
         r = row_cnt;
         c = col_cnt;
         cs = (c < MAXW) ? c : MAXW - 1;
         for (int w = 0; w < 5; w++)
            for (int j = 0; j < 4; j++) win[w][j] = win[w][j + 1];
         win[4][4] = pix;
         base = r % LINES;
         for (int i = 1; i < 5; i++) begin
            slot = (base + LINES - i) % LINES;
            win[4 - i][4] = lines[slot][cs];
         end
         lines[base][cs] = pix;
         if (r >= hh && c >= hw) begin
            q = 0;
            interior = (r - hh >= hh) && (c - hw >= hw) && r < fh && c < fw;
            if (interior && norm != 0) begin
               acc = 0;
               for (int i = 0; i < kh; i++)
                  for (int j = 0; j < kw; j++)
                     acc += longint'(coef(i * GRID + j)) * longint'(win[4 - i][4 - j]);
               q = (acc * 256) / longint'(norm);
               if (q > QLIMIT) q = QLIMIT;
               if (q < -QLIMIT) q = -QLIMIT;
            end
            res.value = q[RESULT_W-1:0];
            res.row = ROW_W'(r - hh);
            res.col = OUT_COL_W'(c - hw);
            res.norm_zero = (norm == 0);
            pending.push_back(res);
         end
         col_cnt = c + 1;
         if (col_cnt >= fw) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= fh) row_cnt = 0;
         end
      endfunction

      function void check_result(conv_result_type got);
         conv_result_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result beat: value %0d row %0d col %0d nz %0b",
                        $signed(got.value), got.row, got.col, got.norm_zero);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: exp value %0d row %0d col %0d nz %0b, got %0d %0d %0d %0b",
                        $signed(want.value), want.row, want.col, want.norm_zero,
                        $signed(got.value), got.row, got.col, got.norm_zero);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // pixel
   logic                   req_tuser;   // first_of_frame
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // result_value, out_row, out_col
   logic                   rsp_tuser;   // norm_zero
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   conv_scoreboard  sb;
   int              sender_idle_pct;
   int              recv_stall_pct;
   int              quiet_cycles;
   conv_result_type beat;

   normalized_kernel_convolution u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: check each accepted beat, then roll the stall for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beat.value = rsp_tdata[16:0];
            beat.row = rsp_tdata[32:17];
            beat.col = rsp_tdata[42:33];
            beat.norm_zero = rsp_tuser;
            sb.check_result(beat);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_pixel(logic [7:0] pix, logic first);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, first);
   endtask

   // Program every register; only called with the block idle.
   task automatic program_regs(logic [63:0] vals [8]);
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.write_reg(CSR_INDEX_W'(i), vals[i]);
      end
      csr_we <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] coef_word(int mode);
      logic [63:0] w;
      for (int b = 0; b < 8; b++) begin
         case (mode)
            0: w[b*8 +: 8] = 8'h00;
            1: w[b*8 +: 8] = 8'h7F;
            2: w[b*8 +: 8] = 8'h80;
            3: w[b*8 +: 8] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(7) - 3);
            default: w[b*8 +: 8] = 8'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic random_setting(int mode);
      logic [63:0] vals [8];
      for (int i = 0; i < 4; i++) vals[i] = coef_word(mode);
      vals[CSR_KERNEL_H] = $urandom_range(7);
      vals[CSR_KERNEL_W] = $urandom_range(7);
      case ($urandom_range(9))
         0: vals[CSR_FRAME_WIDTH] = 0;
         1: vals[CSR_FRAME_WIDTH] = 11'h7FF;
         default: vals[CSR_FRAME_WIDTH] = $urandom_range(16, 1);
      endcase
      case ($urandom_range(9))
         0: vals[CSR_FRAME_HEIGHT] = 0;
         1: vals[CSR_FRAME_HEIGHT] = 16'hFFFF;
         default: vals[CSR_FRAME_HEIGHT] = $urandom_range(8, 1);
      endcase
      program_regs(vals);
   endtask

   task automatic random_run(int count);
      send_pixel(rand_pixel(), 1'b1);
      for (int n = 1; n < count; n++)
         send_pixel(rand_pixel(), ($urandom_range(99) < 3));
   endtask

   initial begin
      logic [63:0] vals [8];
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults with zero normalizer, then full-scale kernels.
      for (int n = 0; n < 5; n++) send_pixel(8'hFF, n == 0);
      vals = '{64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
               64'h7F, 64'd3, 64'd3, 64'd4, 64'd4};
      program_regs(vals);
      for (int n = 0; n < 10; n++) send_pixel((n % 3 == 0) ? 8'h00 : 8'hFF, n == 0);
      vals = '{64'h8080808080808080, 64'h8080808080808080, 64'h8080808080808080,
               64'h80, 64'd5, 64'd5, 64'd5, 64'd5};
      program_regs(vals);
      for (int n = 0; n < 10; n++) send_pixel(8'hFF, n == 0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin sender_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         for (int k = 0; k < 5; k++) begin
            random_setting(k);
            random_run($urandom_range(30, 10));
         end
      end

      // Widest frame, tallest height, single-row kernel: columns run high.
      sender_idle_pct = 0;
      recv_stall_pct = 21;
      vals = '{coef_word(4), coef_word(4), coef_word(4), 64'h5A, 64'd1, 64'd5,
               64'h7FF, 64'd65535};
      program_regs(vals);
      for (int n = 0; n < 520; n++) send_pixel(rand_pixel(), n == 0);

      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
